// ===== sv/cau_pkg.sv =====
// Shared types, constants and tables for the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 30;
  localparam int ANG_FRAC     = 30;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int RES_W        = 26;
  localparam int PROD_W       = 2 * DATA_WIDTH;

  typedef logic signed [DATA_WIDTH-1:0] q_t;
  typedef logic signed [DATA_WIDTH:0]   qx_t;
  typedef logic signed [RES_W-1:0]      res_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef enum logic [3:0] {
    ACT_ADD   = 4'd0,
    ACT_SUB   = 4'd1,
    ACT_MUL   = 4'd2,
    ACT_DIV   = 4'd3,
    ACT_CONJ  = 4'd4,
    ACT_SCALE = 4'd5,
    ACT_EQUAL = 4'd6,
    ACT_MAG   = 4'd7,
    ACT_PHASE = 4'd8
  } act_t;

  // Which back-end unit produces the result.
  typedef enum logic [2:0] {
    CLS_DIRECT,
    CLS_MUL,
    CLS_SCALE,
    CLS_DIV,
    CLS_MAG,
    CLS_PHASE
  } cls_t;

  typedef struct packed {
    logic [3:0] action;
    q_t         a_re;
    q_t         a_im;
    q_t         b_re;
    q_t         b_im;
    q_t         scale;
  } in_word_t;

  typedef struct packed {
    q_t   res_re;
    q_t   res_im;
    logic is_equal;
    logic div_zero;
    logic overflowed;
  } out_word_t;

  typedef struct packed {
    cls_t cls;
    qx_t  d_re;
    qx_t  d_im;
    logic d_eq;
    q_t   a_re;
    q_t   a_im;
    q_t   b_re;
    q_t   b_im;
    q_t   scale;
  } front_word_t;

  typedef struct packed {
    cls_t cls;
    res_t re;
    res_t im;
    logic eq;
    logic dz;
  } carry_t;

  localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;

  // atan(2^-i) in Q30, truncated
  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    unique case (i)
      0:  v = 30'h3243F6A8;
      1:  v = 30'h1DAC6705;
      2:  v = 30'h0FADBAFC;
      3:  v = 30'h07F56EA6;
      4:  v = 30'h03FEAB76;
      5:  v = 30'h01FFD55B;
      6:  v = 30'h00FFFAAA;
      7:  v = 30'h007FFF55;
      8:  v = 30'h003FFFEA;
      9:  v = 30'h001FFFFD;
      10: v = 30'h000FFFFF;
      11: v = 30'h0007FFFF;
      12: v = 30'h0003FFFF;
      13: v = 30'h0001FFFF;
      14: v = 30'h0000FFFF;
      15: v = 30'h00007FFF;
      16: v = 30'h00003FFF;
      17: v = 30'h00001FFF;
      18: v = 30'h00000FFF;
      19: v = 30'h000007FF;
      20: v = 30'h000003FF;
      21: v = 30'h000001FF;
      22: v = 30'h000000FF;
      23: v = 30'h0000007F;
      24: v = 30'h0000003F;
      25: v = 30'h0000001F;
      26: v = 30'h0000000F;
      27: v = 30'h00000007;
      28: v = 30'h00000003;
      29: v = 30'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/cau_front.sv =====
// Front end: decodes the action and resolves the trivial operations.
module cau_front import cau_pkg::*; (
  input  in_word_t    op,
  output front_word_t cw
);

  always_comb begin
    cw       = '0;
    cw.cls   = CLS_DIRECT;
    cw.a_re  = op.a_re;
    cw.a_im  = op.a_im;
    cw.b_re  = op.b_re;
    cw.b_im  = op.b_im;
    cw.scale = op.scale;
    unique case (op.action)
      ACT_ADD: begin
        cw.d_re = qx_t'(op.a_re) + qx_t'(op.b_re);
        cw.d_im = qx_t'(op.a_im) + qx_t'(op.b_im);
      end
      ACT_SUB: begin
        cw.d_re = qx_t'(op.a_re) - qx_t'(op.b_re);
        cw.d_im = qx_t'(op.a_im) - qx_t'(op.b_im);
      end
      ACT_CONJ: begin
        cw.d_re = qx_t'(op.a_re);
        cw.d_im = -qx_t'(op.a_im);
      end
      ACT_EQUAL: cw.d_eq = (op.a_re == op.b_re) && (op.a_im == op.b_im);
      ACT_MUL:   cw.cls = CLS_MUL;
      ACT_DIV:   cw.cls = CLS_DIV;
      ACT_SCALE: cw.cls = CLS_SCALE;
      ACT_MAG:   cw.cls = CLS_MAG;
      ACT_PHASE: cw.cls = CLS_PHASE;
      default:   cw.cls = CLS_DIRECT; // unknown code: all-zero result
    endcase
  end

endmodule

// ===== sv/cau_fifo.sv =====
// Short queue between front and back ends.
module cau_fifo import cau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  front_word_t wr_word,
  output logic        full,
  output logic        rd_valid,
  input  logic        rd_take,
  output front_word_t rd_word
);

  front_word_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp;
  logic [FIFO_AW-1:0] rp;
  logic [FIFO_AW:0]   cnt;

  assign full     = (cnt == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_word  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_en) wp <= wp + 1'b1;
      if (rd_take) rp <= rp + 1'b1;
      cnt <= cnt + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(rd_take);
    end
  end

endmodule

// ===== sv/cau_back.sv =====
// Back end: multipliers, pipelined divider, square root and CORDIC.
module cau_back import cau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  front_word_t in_word,
  output logic        take,
  output logic        res_valid,
  input  logic        res_stall,
  output out_word_t   res_word
);

  localparam int PIPE_D = 32;
  localparam int QB     = 17;            // quotient bits
  localparam int XW     = 42;            // divider dividend width
  localparam int YW     = 33;            // divider divisor width
  localparam int CW     = 34;            // CORDIC x/y width
  localparam int AW     = 35;            // CORDIC angle width
  localparam int SHIFT_A = ANG_FRAC - FRAC_BITS;
  localparam logic signed [33:0] RND_P = 34'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] RND_A = AW'(1) <<< (SHIFT_A - 1);
  localparam res_t Q_MAX = res_t'(1) <<< DATA_WIDTH - 1;
  localparam res_t BIG_Q = res_t'(1) <<< QB;

  logic en;
  logic [PIPE_D:1] vld;
  carry_t car [1:PIPE_D];
  carry_t car_next [2:PIPE_D];

  assign en   = !res_valid || !res_stall;
  assign take = en && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_D-1:1], in_valid};
    end
  end

  // ---- stage 1: products and CORDIC setup
  prod_t p_rr, p_ii, p_ri, p_ir, q_br, q_bi, m_rr, m_ii, s_r, s_i;
  logic signed [CW-1:0] cx [1:CORDIC_STEPS+1];
  logic signed [CW-1:0] cy [1:CORDIC_STEPS+1];
  logic signed [AW-1:0] ca [1:CORDIC_STEPS+1];
  logic                 cz [1:CORDIC_STEPS+1];
  logic signed [CW-1:0] x0, y0;

  assign x0 = CW'(in_word.a_re) <<< 14;
  assign y0 = CW'(in_word.a_im) <<< 14;

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr <= prod_t'(in_word.a_re) * prod_t'(in_word.b_re);
      p_ii <= prod_t'(in_word.a_im) * prod_t'(in_word.b_im);
      p_ri <= prod_t'(in_word.a_re) * prod_t'(in_word.b_im);
      p_ir <= prod_t'(in_word.a_im) * prod_t'(in_word.b_re);
      q_br <= prod_t'(in_word.b_re) * prod_t'(in_word.b_re);
      q_bi <= prod_t'(in_word.b_im) * prod_t'(in_word.b_im);
      m_rr <= prod_t'(in_word.a_re) * prod_t'(in_word.a_re);
      m_ii <= prod_t'(in_word.a_im) * prod_t'(in_word.a_im);
      s_r  <= prod_t'(in_word.a_re) * prod_t'(in_word.scale);
      s_i  <= prod_t'(in_word.a_im) * prod_t'(in_word.scale);
      cz[1] <= (in_word.a_re == '0) && (in_word.a_im == '0);
      if (in_word.a_re < 0) begin
        cx[1] <= -x0;
        cy[1] <= -y0;
        ca[1] <= (in_word.a_im >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        cx[1] <= x0;
        cy[1] <= y0;
        ca[1] <= '0;
      end
    end
  end

  // ---- CORDIC vectoring, one step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [AW-1:0] TAB = AW'(atan_q30(i));
    always_ff @(posedge clk) begin
      if (en) begin
        cz[i+2] <= cz[i+1];
        if (cy[i+1] > 0) begin
          cx[i+2] <= cx[i+1] + (cy[i+1] >>> i);
          cy[i+2] <= cy[i+1] - (cx[i+1] >>> i);
          ca[i+2] <= ca[i+1] + TAB;
        end else begin
          cx[i+2] <= cx[i+1] - (cy[i+1] >>> i);
          cy[i+2] <= cy[i+1] + (cx[i+1] >>> i);
          ca[i+2] <= ca[i+1] - TAB;
        end
      end
    end
  end

  logic signed [AW-1:0] ang_rnd;
  assign ang_rnd = (ca[CORDIC_STEPS+1] + RND_A) >>> SHIFT_A;

  // ---- stage 2: sums for multiply, divide and magnitude
  logic signed [33:0] mre_w, mim_w, sre_w, sim_w;
  assign mre_w = (34'(p_rr) - 34'(p_ii) + RND_P) >>> FRAC_BITS;
  assign mim_w = (34'(p_ri) + 34'(p_ir) + RND_P) >>> FRAC_BITS;
  assign sre_w = (34'(s_r) + RND_P) >>> FRAC_BITS;
  assign sim_w = (34'(s_i) + RND_P) >>> FRAC_BITS;

  logic signed [32:0] dn [2];
  logic [31:0]        dd;
  logic [31:0]        sq_s [2:18];
  logic [31:0]        sq_r [2:18];

  always_ff @(posedge clk) begin
    if (en) begin
      dn[0]   <= 33'(p_rr) + 33'(p_ii);
      dn[1]   <= 33'(p_ir) - 33'(p_ri);
      dd      <= 32'(q_br) + 32'(q_bi);
      sq_s[2] <= 32'(m_rr) + 32'(m_ii);
      sq_r[2] <= '0;
    end
  end

  // ---- divider: setup, range check, then one quotient bit per stage
  logic [XW-1:0] drem [2][3:21];
  logic [QB-1:0] dq   [2][4:21];
  logic          dneg [2][3:21];
  logic          dbig [2][4:21];
  logic [YW-1:0] dy   [3:21];
  logic          ddz  [3:21];
  logic [31:0]   dmag [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign dmag[l] = dn[l][32] ? 32'(-dn[l]) : 32'(dn[l]);

    always_ff @(posedge clk) begin
      if (en) begin
        drem[l][3] <= {1'b0, dmag[l], 9'b0} + XW'(dd);
        dneg[l][3] <= dn[l][32];
        drem[l][4] <= drem[l][3];
        dneg[l][4] <= dneg[l][3];
        dbig[l][4] <= {8'b0, drem[l][3]} >= {dy[3], 17'b0};
        dq[l][4]   <= '0;
      end
    end

    for (genvar t = 5; t <= 21; t++) begin : g_bit
      localparam int K = 21 - t;
      logic [49:0] sub;
      logic        ge;
      assign sub = {17'b0, dy[t-1]} << K;
      assign ge  = {8'b0, drem[l][t-1]} >= sub;
      always_ff @(posedge clk) begin
        if (en) begin
          drem[l][t] <= ge ? drem[l][t-1] - sub[XW-1:0] : drem[l][t-1];
          dq[l][t]   <= {dq[l][t-1][QB-2:0], ge};
          dneg[l][t] <= dneg[l][t-1];
          dbig[l][t] <= dbig[l][t-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dy[3]  <= {dd, 1'b0};
      ddz[3] <= (dd == '0);
      for (int t = 4; t <= 21; t++) begin
        dy[t]  <= dy[t-1];
        ddz[t] <= ddz[t-1];
      end
    end
  end

  function automatic res_t div_val(input logic [QB-1:0] q, input logic big,
                                   input logic neg, input logic dz);
    res_t v;
    v = big ? BIG_Q : res_t'(q);
    if (dz) return '0;
    return neg ? -v : v;
  endfunction

  // ---- square root, one result bit per stage
  for (genvar j = 0; j < 16; j++) begin : g_sqrt
    localparam logic [32:0] BITV = 33'd1 << (30 - 2 * j);
    logic [32:0] trial;
    logic        ge;
    assign trial = {1'b0, sq_r[j+2]} + BITV;
    assign ge    = {1'b0, sq_s[j+2]} >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_s[j+3] <= ge ? sq_s[j+2] - trial[31:0] : sq_s[j+2];
        sq_r[j+3] <= ge ? (sq_r[j+2] >> 1) + BITV[31:0] : (sq_r[j+2] >> 1);
      end
    end
  end

  logic [16:0] sq_rnd;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_rnd <= 17'(sq_r[18]) + 17'(sq_s[18] > sq_r[18]);
    end
  end

  // ---- result carry line; each unit drops its value in at its own stage
  always_comb begin
    for (int t = 2; t <= PIPE_D; t++) car_next[t] = car[t-1];
    if (car[1].cls == CLS_MUL) begin
      car_next[2].re = res_t'(mre_w);
      car_next[2].im = res_t'(mim_w);
    end else if (car[1].cls == CLS_SCALE) begin
      car_next[2].re = res_t'(sre_w);
      car_next[2].im = res_t'(sim_w);
    end
    if (car[19].cls == CLS_MAG) car_next[20].re = res_t'(sq_rnd);
    if (car[21].cls == CLS_DIV) begin
      car_next[22].re = div_val(dq[0][21], dbig[0][21], dneg[0][21], ddz[21]);
      car_next[22].im = div_val(dq[1][21], dbig[1][21], dneg[1][21], ddz[21]);
      car_next[22].dz = ddz[21];
    end
    if (car[31].cls == CLS_PHASE) begin
      car_next[32].re = cz[CORDIC_STEPS+1] ? '0 : res_t'(ang_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car[1].cls <= in_word.cls;
      car[1].re  <= res_t'(in_word.d_re);
      car[1].im  <= res_t'(in_word.d_im);
      car[1].eq  <= in_word.d_eq;
      car[1].dz  <= 1'b0;
      for (int t = 2; t <= PIPE_D; t++) car[t] <= car_next[t];
    end
  end

  // ---- saturation and output register
  function automatic logic too_big(input res_t v);
    return (v > Q_MAX - 1) || (v < -Q_MAX);
  endfunction

  function automatic q_t sat(input res_t v);
    if (v > Q_MAX - 1) return q_t'(Q_MAX - 1);
    if (v < -Q_MAX) return q_t'(-Q_MAX);
    return q_t'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= vld[PIPE_D];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_word.res_re     <= sat(car[PIPE_D].re);
      res_word.res_im     <= sat(car[PIPE_D].im);
      res_word.is_equal   <= car[PIPE_D].eq;
      res_word.div_zero   <= car[PIPE_D].dz;
      res_word.overflowed <= too_big(car[PIPE_D].re) || too_big(car[PIPE_D].im);
    end
  end

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// Complex arithmetic unit top level: front decode, queue, arithmetic back end.
// An accepted word passes through 1 queue slot, 32 back-end stages and the
//   output register; the 30-step CORDIC line sets the depth.
// Throughput: one word per cycle when the result side does not stall.
// Reset (rst, synchronous, active high) empties the queue and clears every
//   stage valid bit; arithmetic registers are not reset.
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_stall,
  input  in_word_t  op_word,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res_word
);

  front_word_t fw;       // decoded word entering the queue
  front_word_t bw;       // head of queue into the back end
  logic        q_full;
  logic        q_valid;
  logic        q_take;

  // Front end is pure decode; the queue register is its output stage.
  cau_front u_front (
    .op (op_word),
    .cw (fw)
  );

  // Input stalls only when the queue is full, so the front keeps taking
  // words while a finished result sits in the output register.
  assign op_stall = q_full;

  cau_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (op_valid && !op_stall),
    .wr_word  (fw),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_word  (bw)
  );

  // Back end advances as a whole whenever its output register can move.
  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_word   (bw),
    .take      (q_take),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule

// ===== sv/cau_check.sv =====
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_check import cau_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      op_valid,
  input logic      op_stall,
  input in_word_t  op_word,
  input logic      res_valid,
  input logic      res_stall,
  input out_word_t res_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("stalled result word changed");

  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.div_zero |->
      res_word.res_re == '0 && res_word.res_im == '0 && !res_word.overflowed)
    else $error("divide by zero word not cleared");

  a_eq: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.is_equal |->
      res_word.res_re == '0 && res_word.res_im == '0 &&
      !res_word.div_zero && !res_word.overflowed)
    else $error("equal word carries data or other flags");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_stall |=> op_valid && $stable(op_word))
    else $error("stalled input word changed");

endmodule

bind complex_arithmetic_unit cau_check u_cau_check (
  .clk       (clk),
  .rst       (rst),
  .op_valid  (op_valid),
  .op_stall  (op_stall),
  .op_word   (op_word),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_word  (res_word)
);
